// ----- design/assert_macros.svh -----
// Assertion macros shared by the checker files.
// Each macro wraps one clocked, reset-gated concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on the rising clock edge, disabled while reset is low.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Assert that an antecedent implies a consequent after the delay given by n.
`define ASSERT_DELAY(label, ante, cons, n) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> ##n (cons)) else $error("latency assertion failed");

`endif

// ----- design/tvi_pkg.sv -----
// Package for the trilinear volume interpolator: widths, register codes,
// reset values and the fixed-point lerp and axis range functions.
// Depends on nothing.
package tvi_pkg;

  localparam int unsigned FRAC_BITS   = 8;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned POS_W       = 21;
  localparam int unsigned COUNT_W     = 13;
  localparam int unsigned CFG_IDX_W   = 2;

  // Integer part of a non-negative position, sign bit excluded.
  localparam int unsigned CORNER_W = POS_W - 1 - FRAC_BITS;
  localparam int unsigned CMP_W    = ((CORNER_W > COUNT_W) ? CORNER_W : COUNT_W) + 1;
  localparam int unsigned ACC_W    = SAMPLE_BITS + FRAC_BITS + 1;

  localparam logic [FRAC_BITS:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_COUNT = 2'd2;

  localparam logic [COUNT_W-1:0] COL_COUNT_RST   = 13'd512;
  localparam logic [COUNT_W-1:0] ROW_COUNT_RST   = 13'd512;
  localparam logic [COUNT_W-1:0] PLANE_COUNT_RST = 13'd150;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [FRAC_BITS-1:0]   frac_t;

  // (a * (1 - f) + b * f) >> FRAC_BITS, truncated.
  function automatic sample_t lerp(input sample_t a, input sample_t b, input frac_t f);
    logic [FRAC_BITS:0] w0;
    logic [ACC_W-1:0]   acc;
    w0  = FRAC_ONE - {1'b0, f};
    acc = ACC_W'(a) * ACC_W'(w0) + ACC_W'(b) * ACC_W'(f);
    return acc[FRAC_BITS +: SAMPLE_BITS];
  endfunction

  // The cell fits when the position is non-negative and floor + 1 < count.
  function automatic logic axis_ok(input logic [POS_W-1:0] pos,
                                   input logic [COUNT_W-1:0] count);
    logic [CMP_W-1:0] next_corner;
    next_corner = CMP_W'(pos[POS_W-2:FRAC_BITS]) + CMP_W'(1);
    return !pos[POS_W-1] && (next_corner < CMP_W'(count));
  endfunction

endpackage

// ----- design/trilinear_volume_interpolator_core.sv -----
// Trilinear volume interpolator, top level: four-stage pipeline.
// Depends on tvi_pkg.
//
//  channel   handshake            payload
//  --------  -------------------  ------------------------------------------
//  request   start_i / busy_o     pos_x_i, pos_y_i, pos_z_i, corner_000..111_i
//  result    valid_o (strobe)     value_o, in_range_o
//  config    cfg_we_i             cfg_idx_i, cfg_wdata_i
//
// A request is taken on every cycle; busy_o stays low. Each result appears
// as one pulse of valid_o, in request order.
// The depth is set by the three lerp stages (z, x, y), one 16x9 and one
// 16x8 multiply per lerp, plus the input register with the range check.
// Reset clears the valid bits and loads the count registers; the data path
// carries no reset. The receiver cannot stall, so nothing holds in the pipe.
module trilinear_volume_interpolator_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic signed [tvi_pkg::POS_W-1:0]    pos_x_i,
  input  logic signed [tvi_pkg::POS_W-1:0]    pos_y_i,
  input  logic signed [tvi_pkg::POS_W-1:0]    pos_z_i,
  input  logic [tvi_pkg::SAMPLE_BITS-1:0]     corner_000_i,
  input  logic [tvi_pkg::SAMPLE_BITS-1:0]     corner_001_i,
  input  logic [tvi_pkg::SAMPLE_BITS-1:0]     corner_010_i,
  input  logic [tvi_pkg::SAMPLE_BITS-1:0]     corner_011_i,
  input  logic [tvi_pkg::SAMPLE_BITS-1:0]     corner_100_i,
  input  logic [tvi_pkg::SAMPLE_BITS-1:0]     corner_101_i,
  input  logic [tvi_pkg::SAMPLE_BITS-1:0]     corner_110_i,
  input  logic [tvi_pkg::SAMPLE_BITS-1:0]     corner_111_i,
  output logic                                valid_o,
  output logic [tvi_pkg::SAMPLE_BITS-1:0]     value_o,
  output logic                                in_range_o,
  input  logic                                cfg_we_i,
  input  logic [tvi_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [tvi_pkg::COUNT_W-1:0]         cfg_wdata_i
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [tvi_pkg::COUNT_W-1:0] col_count_q, row_count_q, plane_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_count_q   <= tvi_pkg::COL_COUNT_RST;
      row_count_q   <= tvi_pkg::ROW_COUNT_RST;
      plane_count_q <= tvi_pkg::PLANE_COUNT_RST;
    end else if (cfg_we_i) begin
      // Drop writes to indexes past the register list.
      unique case (cfg_idx_i)
        tvi_pkg::CFG_COL_COUNT:   col_count_q   <= cfg_wdata_i;
        tvi_pkg::CFG_ROW_COUNT:   row_count_q   <= cfg_wdata_i;
        tvi_pkg::CFG_PLANE_COUNT: plane_count_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The pipe never stalls, so every request is taken.
  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  // ---------------------------------------------------------------------
  // Stage 1: register the request, check the cell against the volume
  // ---------------------------------------------------------------------
  logic                    s1_valid_q;
  logic                    s1_ok_q;
  tvi_pkg::frac_t          s1_fx_q, s1_fy_q, s1_fz_q;
  tvi_pkg::sample_t        s1_c_q [8];
  logic                    s1_ok_d;

  assign s1_ok_d = tvi_pkg::axis_ok(pos_x_i, col_count_q)
                && tvi_pkg::axis_ok(pos_y_i, row_count_q)
                && tvi_pkg::axis_ok(pos_z_i, plane_count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_ok_q   <= s1_ok_d;
    s1_fx_q   <= pos_x_i[tvi_pkg::FRAC_BITS-1:0];
    s1_fy_q   <= pos_y_i[tvi_pkg::FRAC_BITS-1:0];
    s1_fz_q   <= pos_z_i[tvi_pkg::FRAC_BITS-1:0];
    // Index bits: x, y, z from high to low.
    s1_c_q[0] <= corner_000_i;
    s1_c_q[1] <= corner_001_i;
    s1_c_q[2] <= corner_010_i;
    s1_c_q[3] <= corner_011_i;
    s1_c_q[4] <= corner_100_i;
    s1_c_q[5] <= corner_101_i;
    s1_c_q[6] <= corner_110_i;
    s1_c_q[7] <= corner_111_i;
  end

  // ---------------------------------------------------------------------
  // Stage 2: four lerps along z
  // ---------------------------------------------------------------------
  logic             s2_valid_q;
  logic             s2_ok_q;
  tvi_pkg::frac_t   s2_fx_q, s2_fy_q;
  tvi_pkg::sample_t s2_x0y0_q, s2_x1y0_q, s2_x0y1_q, s2_x1y1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_ok_q   <= s1_ok_q;
    s2_fx_q   <= s1_fx_q;
    s2_fy_q   <= s1_fy_q;
    s2_x0y0_q <= tvi_pkg::lerp(s1_c_q[0], s1_c_q[1], s1_fz_q);
    s2_x1y0_q <= tvi_pkg::lerp(s1_c_q[4], s1_c_q[5], s1_fz_q);
    s2_x0y1_q <= tvi_pkg::lerp(s1_c_q[2], s1_c_q[3], s1_fz_q);
    s2_x1y1_q <= tvi_pkg::lerp(s1_c_q[6], s1_c_q[7], s1_fz_q);
  end

  // ---------------------------------------------------------------------
  // Stage 3: two lerps along x
  // ---------------------------------------------------------------------
  logic             s3_valid_q;
  logic             s3_ok_q;
  tvi_pkg::frac_t   s3_fy_q;
  tvi_pkg::sample_t s3_y0_q, s3_y1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_ok_q <= s2_ok_q;
    s3_fy_q <= s2_fy_q;
    s3_y0_q <= tvi_pkg::lerp(s2_x0y0_q, s2_x1y0_q, s2_fx_q);
    s3_y1_q <= tvi_pkg::lerp(s2_x0y1_q, s2_x1y1_q, s2_fx_q);
  end

  // ---------------------------------------------------------------------
  // Stage 4: lerp along y, force zero outside the volume
  // ---------------------------------------------------------------------
  logic             out_valid_q;
  logic             out_ok_q;
  tvi_pkg::sample_t out_value_q;
  tvi_pkg::sample_t out_value_d;

  assign out_value_d = s3_ok_q ? tvi_pkg::lerp(s3_y0_q, s3_y1_q, s3_fy_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    out_ok_q    <= s3_ok_q;
    out_value_q <= out_value_d;
  end

  assign valid_o    = out_valid_q;
  assign value_o    = out_value_q;
  assign in_range_o = out_ok_q;

endmodule

// ----- design/tvi_checker.sv -----
// Port-level checker for the trilinear volume interpolator and its bind.
// Depends on tvi_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tvi_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start_i,
  input logic                            busy_i,
  input logic                            valid_i,
  input logic [tvi_pkg::SAMPLE_BITS-1:0] value_i,
  input logic                            in_range_i
);

  // Every request gives its result, after the input register and the three lerp stages.
  `ASSERT_DELAY(req_to_result, start_i && !busy_i, valid_i, 4)
  // No result without a request that has passed the input register and the three lerp stages.
  `ASSERT_CLK(no_spurious_result, !valid_i || $past(start_i && !busy_i, 4))
  // A cell outside the volume reads as zero.
  `ASSERT_CLK(out_of_range_zero, !(valid_i && !in_range_i) || (value_i == '0))
  // The pipe never pushes back on requests.
  `ASSERT_CLK(never_busy, !busy_i)

endmodule

bind trilinear_volume_interpolator_core tvi_checker u_tvi_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .busy_i     (busy_o),
  .valid_i    (valid_o),
  .value_i    (value_o),
  .in_range_i (in_range_o)
);
